### rtl/lsbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsbe_pkg;

  // Strip size and derived widths
  localparam int LED_COUNT    = 64;
  localparam int LED_IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_CNT_W    = $clog2(LED_COUNT + 1);
  localparam int COLOUR_BITS  = 24;
  localparam int BIT_CNT_W    = 5;
  localparam int POS_W        = 10;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  // Register reset values
  localparam logic [CFG_W-1:0] BIT_PERIOD_LAST_RST = 16'd79;
  localparam logic [CFG_W-1:0] ZERO_HIGH_RST       = 16'd16;
  localparam logic [CFG_W-1:0] ONE_HIGH_RST        = 16'd38;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD_LAST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH        = 2'd2;

  // Request kinds on the input channel
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Classified operations handed to the back end
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_DROP  = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [POS_W-1:0] position;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic ignored;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [LED_IDX_W-1:0]   pos;
    logic [COLOUR_BITS-1:0] colour;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/lsbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lsbe_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lsbe_pkg::in_item_t in_data,
  output logic                  push,
  output lsbe_pkg::cmd_t        push_cmd,
  input  wire logic             q_full
);

  logic           front_valid_r;
  lsbe_pkg::cmd_t front_cmd_r;
  lsbe_pkg::cmd_t cmd_nxt;

  // Classify the incoming request
  always_comb begin
    cmd_nxt.pos    = in_data.position[lsbe_pkg::LED_IDX_W-1:0];
    cmd_nxt.colour = {in_data.blue, in_data.red, in_data.green};
    case (in_data.kind)
      lsbe_pkg::KIND_SET: begin
        if ({1'b0, in_data.position} < (lsbe_pkg::POS_W + 1)'(lsbe_pkg::LED_COUNT)) begin
          cmd_nxt.op = lsbe_pkg::OP_SET;
        end else begin
          cmd_nxt.op = lsbe_pkg::OP_DROP;
        end
      end
      lsbe_pkg::KIND_START: cmd_nxt.op = lsbe_pkg::OP_START;
      lsbe_pkg::KIND_TICK:  cmd_nxt.op = lsbe_pkg::OP_TICK;
      default:              cmd_nxt.op = lsbe_pkg::OP_DROP;
    endcase
  end

  // Hold while the queue cannot take the staged request
  assign in_stall = front_valid_r && q_full;
  assign push     = front_valid_r && !q_full;
  assign push_cmd = front_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (!in_stall) begin
      front_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      front_cmd_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/lsbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module lsbe_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lsbe_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output lsbe_pkg::cmd_t      head
);

  lsbe_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/lsbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lsbe_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_not_empty,
  input  wire lsbe_pkg::cmd_t                     q_head,
  output logic                                    pop,
  input  wire logic                               cfg_valid,
  input  wire logic [lsbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsbe_pkg::CFG_W-1:0]         cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output lsbe_pkg::out_item_t                     out_data
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LEAD  = 2'd1;
  localparam logic [1:0] PH_BITS  = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  localparam int IW = lsbe_pkg::LED_IDX_W;
  localparam int CW = lsbe_pkg::LED_CNT_W;
  localparam int BW = lsbe_pkg::BIT_CNT_W;
  localparam int DW = lsbe_pkg::COLOUR_BITS;
  localparam int TW = lsbe_pkg::CFG_W;

  // Configuration
  logic [TW-1:0] bit_period_last_r;
  logic [TW-1:0] zero_high_r;
  logic [TW-1:0] one_high_r;

  // Sequencer state
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] led_r, led_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [TW-1:0] high_r, high_nxt;

  // Per-entry bank bookkeeping
  logic [lsbe_pkg::LED_COUNT-1:0] cur_bank_r;
  logic [lsbe_pkg::LED_COUNT-1:0] snap_bank_r;
  logic [lsbe_pkg::LED_COUNT-1:0] written_r;
  logic [lsbe_pkg::LED_COUNT-1:0] snap_vld_r;

  // Colour banks
  logic [DW-1:0] bank0 [lsbe_pkg::LED_COUNT];
  logic [DW-1:0] bank1 [lsbe_pkg::LED_COUNT];
  logic [DW-1:0] bank0_q_r;
  logic [DW-1:0] bank1_q_r;
  logic          rd_sel_r;
  logic          rd_vld_r;
  logic [DW-1:0] rd_word;

  logic          exec;
  logic          do_set;
  logic          do_start;
  logic          wr_bank;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] led_inc;
  logic [CW-1:0] look_inc;
  logic [BW-1:0] bit_idx;
  logic          ignored;
  logic          done;
  logic          busy_nxt;
  logic          out_valid_r;
  lsbe_pkg::out_item_t out_r;

  // Execute the head request when the output register is free
  assign exec     = q_not_empty && (!out_valid_r || !out_stall);
  assign pop      = exec;
  assign do_set   = exec && (q_head.op == lsbe_pkg::OP_SET);
  assign do_start = exec && (q_head.op == lsbe_pkg::OP_START) && (phase_r == PH_IDLE);
  assign wr_bank  = !snap_bank_r[q_head.pos];

  assign rd_word = rd_vld_r ? (rd_sel_r ? bank1_q_r : bank0_q_r) : '0;
  assign led_inc = led_r + CW'(1);

  // Sequencer next state
  always_comb begin
    phase_nxt = phase_r;
    led_nxt   = led_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    high_nxt  = high_r;
    ignored   = 1'b0;
    done      = 1'b0;
    bit_idx   = '0;
    if (exec) begin
      case (q_head.op)
        lsbe_pkg::OP_START: begin
          if (phase_r != PH_IDLE) begin
            ignored = 1'b1;
          end else begin
            phase_nxt = PH_LEAD;
            led_nxt   = '0;
            bit_nxt   = '0;
            tick_nxt  = '0;
            high_nxt  = '0;
          end
        end
        lsbe_pkg::OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (tick_r < bit_period_last_r) begin
              tick_nxt = tick_r + TW'(1);
            end else begin
              tick_nxt = '0;
              case (phase_r)
                PH_LEAD: begin
                  phase_nxt = PH_BITS;
                  led_nxt   = '0;
                  bit_nxt   = '0;
                  bit_idx   = BW'(DW - 1);
                  high_nxt  = rd_word[bit_idx] ? one_high_r : zero_high_r;
                end
                PH_BITS: begin
                  if (bit_r == BW'(DW - 1)) begin
                    bit_nxt = '0;
                    led_nxt = led_inc;
                  end else begin
                    bit_nxt = bit_r + BW'(1);
                  end
                  if (led_nxt >= CW'(lsbe_pkg::LED_COUNT)) begin
                    phase_nxt = PH_TRAIL;
                    high_nxt  = '0;
                  end else begin
                    bit_idx  = BW'(DW - 1) - bit_nxt;
                    high_nxt = rd_word[bit_idx] ? one_high_r : zero_high_r;
                  end
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  high_nxt  = '0;
                  led_nxt   = '0;
                  bit_nxt   = '0;
                  done      = 1'b1;
                end
              endcase
            end
          end
        end
        lsbe_pkg::OP_SET: begin
        end
        default: ignored = 1'b1;
      endcase
    end
  end

  // Prefetch the word the next period start will need
  assign look_inc = led_nxt + CW'(1);
  always_comb begin
    if (phase_nxt == PH_LEAD) begin
      rd_addr = '0;
    end else if (bit_nxt == BW'(DW - 1)) begin
      rd_addr = (look_inc == CW'(lsbe_pkg::LED_COUNT)) ? '0 : look_inc[IW-1:0];
    end else begin
      rd_addr = led_nxt[IW-1:0];
    end
  end

  assign busy_nxt = (phase_nxt != PH_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      led_r   <= '0;
      bit_r   <= '0;
      tick_r  <= '0;
      high_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      led_r   <= led_nxt;
      bit_r   <= bit_nxt;
      tick_r  <= tick_nxt;
      high_r  <= high_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_last_r <= lsbe_pkg::BIT_PERIOD_LAST_RST;
      zero_high_r       <= lsbe_pkg::ZERO_HIGH_RST;
      one_high_r        <= lsbe_pkg::ONE_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsbe_pkg::CFG_BIT_PERIOD_LAST: bit_period_last_r <= cfg_data;
        lsbe_pkg::CFG_ZERO_HIGH:       zero_high_r       <= cfg_data;
        lsbe_pkg::CFG_ONE_HIGH:        one_high_r        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Bank bookkeeping: a write lands in the bank the snapshot does not use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_bank_r  <= '0;
      snap_bank_r <= '0;
      written_r   <= '0;
      snap_vld_r  <= '0;
    end else if (do_set) begin
      cur_bank_r[q_head.pos] <= wr_bank;
      written_r[q_head.pos]  <= 1'b1;
    end else if (do_start) begin
      snap_bank_r <= cur_bank_r;
      snap_vld_r  <= written_r;
    end
  end

  // Colour banks, one write and one registered read each
  always_ff @(posedge clk) begin
    if (do_set && !wr_bank) begin
      bank0[q_head.pos] <= q_head.colour;
    end
    bank0_q_r <= bank0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (do_set && wr_bank) begin
      bank1[q_head.pos] <= q_head.colour;
    end
    bank1_q_r <= bank1[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_sel_r <= do_start ? cur_bank_r[rd_addr] : snap_bank_r[rd_addr];
    rd_vld_r <= do_start ? written_r[rd_addr] : snap_vld_r[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_r.line_level <= busy_nxt && (tick_nxt < high_nxt);
      out_r.busy_res   <= busy_nxt;
      out_r.ignored    <= ignored;
      out_r.frame_done <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### rtl/led_strip_bit_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// One-wire LED strip encoder. Each request is a set-colour, a frame start or one
// timer tick, and each gives exactly one result: line level, busy, ignored and
// frame-done. One request per clock is sustained when the output does not
// stall; a request passes the classifying front register, a two-entry queue
// and the sequencer into the result register. The frame snapshot costs no
// copy time: colours live in two banks with a bank bit per LED, a start just
// latches those bits, and the sequencer prefetches the next LED word through
// the banks' registered read port. No clearing pass is run after reset.
module led_strip_bit_encoder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire lsbe_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output lsbe_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lsbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lsbe_pkg::CFG_W-1:0]     cfg_data
);

  logic           push;
  lsbe_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           pop;
  logic           q_not_empty;
  lsbe_pkg::cmd_t q_head;

  assign cfg_ready = 1'b1;

  lsbe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  lsbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lsbe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
